>>> src/weighted_cluster_head_election_defines.svh
// Assertion macros for the RTL file that carries checks.
`ifndef WEIGHTED_CLUSTER_HEAD_ELECTION_DEFINES_SVH
`define WEIGHTED_CLUSTER_HEAD_ELECTION_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define WCHE_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("invariant violated");

// An antecedent that must be met by a consequent in the same cycle.
`define WCHE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication violated");

`endif

>>> src/wche_pkg.sv
package wche_pkg;

    localparam int ADDR_W = 32;
    localparam int WT_W   = 16;
    localparam int DEG_W  = 9;

    // Input kinds.
    localparam logic [2:0] K_HELLO = 3'd0;
    localparam logic [2:0] K_ANN   = 3'd1;
    localparam logic [2:0] K_JREQ  = 3'd2;
    localparam logic [2:0] K_JREP  = 3'd3;
    localparam logic [2:0] K_ELEC  = 3'd4;
    localparam logic [2:0] K_HTICK = 3'd5;
    localparam logic [2:0] K_TTICK = 3'd6;

    // Output actions.
    localparam logic [2:0] A_NONE  = 3'd0;
    localparam logic [2:0] A_HELLO = 3'd1;
    localparam logic [2:0] A_ANN   = 3'd2;
    localparam logic [2:0] A_JOIN  = 3'd3;
    localparam logic [2:0] A_REPLY = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MY_ADDR = 3'd0;
    localparam logic [2:0] CFG_TIMEOUT = 3'd1;
    localparam logic [2:0] CFG_DW      = 3'd2;
    localparam logic [2:0] CFG_TW      = 3'd3;
    localparam logic [2:0] CFG_MW      = 3'd4;
    localparam logic [2:0] CFG_BW      = 3'd5;

    localparam logic [ADDR_W-1:0] BCAST = '1;

    typedef struct packed {
        logic [DEG_W-1:0] degree;
        logic [9:0]       speed;
        logic [8:0]       battery;
        logic [11:0]      dw;
        logic [11:0]      tw;
        logic [11:0]      mw;
        logic [11:0]      bw;
    } t_wgt_req;

endpackage

>>> src/wche_in_if.sv
interface wche_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [31:0]        src_address;
    logic [31:0]        head_address;
    logic signed [15:0] neighbor_weight;
    logic [9:0]         own_speed;
    logic [8:0]         own_battery;

    modport source (output valid, kind, src_address, head_address, neighbor_weight,
                    own_speed, own_battery, input ready);
    modport sink (input valid, kind, src_address, head_address, neighbor_weight,
                  own_speed, own_battery, output ready);
endinterface

>>> src/wche_out_if.sv
interface wche_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [31:0]        dest_address;
    logic [31:0]        head_address_out;
    logic signed [15:0] own_weight;
    logic [5:0]         degree;
    logic               is_head;
    logic [5:0]         member_count;
    logic               table_full;

    modport source (output valid, action, dest_address, head_address_out, own_weight,
                    degree, is_head, member_count, table_full, input ready);
    modport sink (input valid, action, dest_address, head_address_out, own_weight,
                  degree, is_head, member_count, table_full, output ready);
endinterface

>>> src/wche_weight.sv
module wche_weight (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  wche_pkg::t_wgt_req        i_req,
    output logic                      o_done,
    output logic signed [15:0]        o_weight
);

    localparam int AW = 30;
    localparam int NW = 22;
    localparam int ROUND = 640;
    localparam int DIV_BIAS = 5 * (1 << 18);
    localparam int QBIAS = 1 << 18;
    // Reciprocal of five scaled by 2^25, rounded up.
    localparam logic [22:0] RECIP5 = 23'd6710887;

    localparam logic [2:0] W_IDLE = 3'd0;
    localparam logic [2:0] W_MUL  = 3'd1;
    localparam logic [2:0] W_ADD  = 3'd2;
    localparam logic [2:0] W_PREP = 3'd3;
    localparam logic [2:0] W_DIV  = 3'd4;
    localparam logic [2:0] W_FIN  = 3'd5;

    logic [2:0]           r_state;
    logic [1:0]           r_step;
    wche_pkg::t_wgt_req   r_req;
    logic signed [23:0]   r_prod;
    logic signed [AW-1:0] r_acc;
    logic [NW-1:0]        r_num;
    logic signed [15:0]   r_wt;
    logic                 r_done;

    logic [9:0]           spd_c;
    logic signed [12:0]   mul_a;
    logic signed [10:0]   mul_b;
    logic signed [23:0]   mul_p;
    logic signed [AW-1:0] p_ext;
    logic signed [AW-1:0] addend;
    logic signed [AW-1:0] acc_sh;
    logic [44:0]          quo_p;
    logic signed [NW:0]   q_c;

    assign spd_c = (r_req.speed > 10'd160) ? 10'd160 : r_req.speed;

    // One multiplier serves the degree, mobility and battery terms in turn.
    always_comb begin
        case (r_step)
            2'd0: begin
                mul_a = $signed({1'b0, r_req.dw});
                mul_b = 11'sd10 - $signed({2'b00, r_req.degree});
            end
            2'd1: begin
                mul_a = $signed({1'b0, r_req.mw});
                mul_b = $signed({1'b0, spd_c});
            end
            default: begin
                mul_a = $signed({1'b0, r_req.bw});
                mul_b = 11'sd256 - $signed({2'b00, r_req.battery});
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign p_ext = {{(AW-24){r_prod[23]}}, r_prod};

    always_comb begin
        case (r_step)
            2'd0:    addend = p_ext <<< 7;
            2'd1:    addend = p_ext <<< 3;
            default: addend = (p_ext <<< 2) + p_ext;
        endcase
    end

    assign acc_sh = (r_acc >>> 8) + AW'(DIV_BIAS);
    // The product's upper bits are the exact floor of the dividend over five.
    assign quo_p  = r_num * RECIP5;
    assign q_c    = $signed({1'b0, r_num}) - (NW+1)'(QBIAS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
            r_done  <= 1'b0;
            r_step  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                W_IDLE: begin
                    if (i_start) begin
                        r_req   <= i_req;
                        r_step  <= 2'd0;
                        r_acc   <= $signed({8'b0, i_req.tw, 10'b0})
                                 + $signed({10'b0, i_req.tw, 8'b0}) + AW'(ROUND);
                        r_state <= W_MUL;
                    end
                end
                W_MUL: begin
                    r_prod  <= mul_p;
                    r_state <= W_ADD;
                end
                W_ADD: begin
                    r_acc <= r_acc + addend;
                    if (r_step == 2'd2) begin
                        r_state <= W_PREP;
                    end else begin
                        r_step  <= r_step + 2'd1;
                        r_state <= W_MUL;
                    end
                end
                W_PREP: begin
                    // Floor by 256 is the shift; the bias keeps the dividend positive.
                    r_num   <= acc_sh[NW-1:0];
                    r_state <= W_DIV;
                end
                W_DIV: begin
                    // Floor division by five as a multiply by its scaled reciprocal.
                    r_num   <= {2'b00, quo_p[44:25]};
                    r_state <= W_FIN;
                end
                W_FIN: begin
                    if (q_c > (NW+1)'(32767)) begin
                        r_wt <= 16'sh7fff;
                    end else if (q_c < -(NW+1)'(32768)) begin
                        r_wt <= 16'sh8000;
                    end else begin
                        r_wt <= q_c[15:0];
                    end
                    r_done  <= 1'b1;
                    r_state <= W_IDLE;
                end
                default: r_state <= W_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_weight = r_wt;

endmodule

>>> src/weighted_cluster_head_election.sv
// Channel   | Direction | Modport | Carries
// i_req     | in        | sink    | one message or tick request per item
// o_rsp     | out       | source  | one result per accepted request
// i_cfg_*   | in        | write   | register index and data, no read-back
//
// Every request first runs the shared weight unit.
// Hello and join requests then scan their table.
// An election scans the neighbor table, then ages it entry by entry (read, check,
// next), with a member sweep for each stale neighbor while the member table is not empty.
// Reset is synchronous and active low; it clears all valid bits and counters.
// The result register lets a new request enter while the last result is unread.
module weighted_cluster_head_election #(
    parameter int NEIGHBOR_DEPTH = 32,
    parameter int MEMBER_DEPTH   = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wche_in_if.sink           i_req,
    wche_out_if.source        o_rsp,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data
);

`include "weighted_cluster_head_election_defines.svh"

    localparam int NIW = $clog2(NEIGHBOR_DEPTH);
    localparam int MIW = $clog2(MEMBER_DEPTH);
    localparam int NCW = $clog2(NEIGHBOR_DEPTH + 1);
    localparam int MCW = $clog2(MEMBER_DEPTH + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WGT     = 4'd1;
    localparam logic [3:0] S_HSCAN   = 4'd2;
    localparam logic [3:0] S_HFIN    = 4'd3;
    localparam logic [3:0] S_MSCAN   = 4'd4;
    localparam logic [3:0] S_MFIN    = 4'd5;
    localparam logic [3:0] S_ESCAN   = 4'd6;
    localparam logic [3:0] S_ELEC    = 4'd7;
    localparam logic [3:0] S_AGE_RD  = 4'd8;
    localparam logic [3:0] S_AGE_CHK = 4'd9;
    localparam logic [3:0] S_DROP    = 4'd10;
    localparam logic [3:0] S_AGE_NXT = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    // Table storage; only entries with their valid bit set are ever used.
    logic [31:0]        m_nbr_addr [NEIGHBOR_DEPTH];
    logic signed [15:0] m_nbr_wt   [NEIGHBOR_DEPTH];
    logic [31:0]        m_nbr_seen [NEIGHBOR_DEPTH];
    logic [31:0]        m_mem_addr [MEMBER_DEPTH];

    logic [31:0]        r_q_naddr;
    logic signed [15:0] r_q_nwt;
    logic [31:0]        r_q_nseen;
    logic [31:0]        r_q_maddr;

    // Configuration registers.
    logic [31:0] r_my_addr;
    logic [15:0] r_timeout;
    logic [11:0] r_dw, r_tw, r_mw, r_bw;

    // Protocol state.
    logic [NEIGHBOR_DEPTH-1:0] r_nbr_vld;
    logic [NCW-1:0]            r_nbr_cnt;
    logic [MEMBER_DEPTH-1:0]   r_mem_vld;
    logic [MCW-1:0]            r_mem_cnt;
    logic                      r_head;
    logic [31:0]               r_cur_head;
    logic [31:0]               r_now;

    // Sequencer and current request.
    logic [3:0]         r_state;
    logic [2:0]         r_kind;
    logic [31:0]        r_src;
    logic [31:0]        r_hd;
    logic signed [15:0] r_nw;
    logic signed [15:0] r_mine;

    // Scan bookkeeping.
    logic [NIW-1:0]     r_nptr, r_npidx, r_slot, r_fslot;
    logic [MIW-1:0]     r_mptr, r_mpidx, r_mfslot;
    logic               r_issue, r_pv;
    logic               r_hit, r_free, r_mhit, r_mfree, r_found;
    logic signed [15:0] r_best_wt;
    logic [31:0]        r_best_addr;
    logic [31:0]        r_drop_addr;

    // Result under construction and the result register.
    logic [2:0]         r_act;
    logic [31:0]        r_dest, r_hout;
    logic               r_full;
    logic               r_ov;
    logic [2:0]         r_o_act;
    logic [31:0]        r_o_dest, r_o_hout;
    logic signed [15:0] r_o_wt;
    logic [5:0]         r_o_deg, r_o_mcnt;
    logic               r_o_head, r_o_full;

    logic                 accept;
    logic                 w_done;
    logic signed [15:0]   w_wt;
    wche_pkg::t_wgt_req   w_req;
    logic                 nbr_we;
    logic [NIW-1:0]       nbr_wa;
    logic                 mem_we;
    logic                 nbr_last, mem_last;
    logic                 e_cand, e_better, stale_c, m_match;
    logic [31:0]          m_key;
    logic                 load_out;

    assign accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // The degree seen by the weight is the table fill at the start of the request.
    assign w_req.degree  = wche_pkg::DEG_W'(r_nbr_cnt);
    assign w_req.speed   = i_req.own_speed;
    assign w_req.battery = i_req.own_battery;
    assign w_req.dw      = r_dw;
    assign w_req.tw      = r_tw;
    assign w_req.mw      = r_mw;
    assign w_req.bw      = r_bw;

    wche_weight u_weight (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_req    (w_req),
        .o_done   (w_done),
        .o_weight (w_wt)
    );

    assign nbr_last = (r_nptr == NIW'(NEIGHBOR_DEPTH - 1));
    assign mem_last = (r_mptr == MIW'(MEMBER_DEPTH - 1));

    // A hello refreshes a known slot in place or claims the first free one.
    assign nbr_we = (r_state == S_HFIN) && (r_hit || r_free);
    assign nbr_wa = r_hit ? r_slot : r_fslot;
    assign mem_we = (r_state == S_MFIN) && !r_mhit && r_mfree;

    // The election keeps the lightest strictly lighter neighbor, lowest address on ties.
    assign e_cand   = r_nbr_vld[r_npidx] && (r_q_nwt < r_mine);
    assign e_better = !r_found || (r_q_nwt < r_best_wt)
                   || ((r_q_nwt == r_best_wt) && (r_q_naddr < r_best_addr));
    assign stale_c  = r_nbr_vld[r_nptr] && ((r_now - r_q_nseen) > {16'b0, r_timeout});
    assign m_key    = (r_state == S_DROP) ? r_drop_addr : r_src;
    assign m_match  = r_mem_vld[r_mpidx] && (r_q_maddr == m_key);
    assign load_out = (r_state == S_DONE) && (!r_ov || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        r_q_naddr <= m_nbr_addr[r_nptr];
        r_q_nwt   <= m_nbr_wt[r_nptr];
        r_q_nseen <= m_nbr_seen[r_nptr];
        if (nbr_we) begin
            m_nbr_addr[nbr_wa] <= r_src;
            m_nbr_wt[nbr_wa]   <= r_nw;
            m_nbr_seen[nbr_wa] <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_maddr <= m_mem_addr[r_mptr];
        if (mem_we) begin
            m_mem_addr[r_mfslot] <= r_src;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_my_addr  <= 32'd1;
            r_timeout  <= 16'd50;
            r_dw       <= 12'd179;
            r_tw       <= 12'd26;
            r_mw       <= 12'd26;
            r_bw       <= 12'd26;
            r_nbr_vld  <= '0;
            r_nbr_cnt  <= '0;
            r_mem_vld  <= '0;
            r_mem_cnt  <= '0;
            r_head     <= 1'b0;
            r_cur_head <= 32'd0;
            r_now      <= 32'd0;
            r_ov       <= 1'b0;
            r_issue    <= 1'b0;
            r_pv       <= 1'b0;
            r_nptr     <= '0;
            r_mptr     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    wche_pkg::CFG_MY_ADDR: r_my_addr <= i_cfg_data;
                    wche_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data[15:0];
                    wche_pkg::CFG_DW:      r_dw      <= i_cfg_data[11:0];
                    wche_pkg::CFG_TW:      r_tw      <= i_cfg_data[11:0];
                    wche_pkg::CFG_MW:      r_mw      <= i_cfg_data[11:0];
                    wche_pkg::CFG_BW:      r_bw      <= i_cfg_data[11:0];
                    default: ;
                endcase
            end

            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind  <= i_req.kind;
                        r_src   <= i_req.src_address;
                        r_hd    <= i_req.head_address;
                        r_nw    <= i_req.neighbor_weight;
                        r_act   <= wche_pkg::A_NONE;
                        r_dest  <= 32'd0;
                        r_hout  <= 32'd0;
                        r_full  <= 1'b0;
                        r_state <= S_WGT;
                    end
                end
                S_WGT: begin
                    if (w_done) begin
                        r_mine  <= w_wt;
                        r_state <= S_DONE;
                        unique case (r_kind)
                            wche_pkg::K_HELLO: begin
                                // A node ignores its own hello.
                                if (r_src != r_my_addr) begin
                                    r_nptr  <= '0;
                                    r_issue <= 1'b1;
                                    r_pv    <= 1'b0;
                                    r_hit   <= 1'b0;
                                    r_free  <= 1'b0;
                                    r_state <= S_HSCAN;
                                end
                            end
                            wche_pkg::K_ANN: begin
                                if (!r_head && (r_cur_head == 32'd0)) begin
                                    r_cur_head <= r_hd;
                                    r_act      <= wche_pkg::A_JOIN;
                                    r_dest     <= r_hd;
                                    r_hout     <= r_hd;
                                end
                            end
                            wche_pkg::K_JREQ: begin
                                if (r_head) begin
                                    r_mptr  <= '0;
                                    r_issue <= 1'b1;
                                    r_pv    <= 1'b0;
                                    r_mhit  <= 1'b0;
                                    r_mfree <= 1'b0;
                                    r_state <= S_MSCAN;
                                end
                            end
                            wche_pkg::K_JREP: r_cur_head <= r_hd;
                            wche_pkg::K_ELEC: begin
                                r_nptr  <= '0;
                                r_issue <= 1'b1;
                                r_pv    <= 1'b0;
                                r_found <= 1'b0;
                                r_state <= S_ESCAN;
                            end
                            wche_pkg::K_HTICK: begin
                                r_act  <= wche_pkg::A_HELLO;
                                r_dest <= wche_pkg::BCAST;
                                r_hout <= r_head ? r_my_addr : r_cur_head;
                            end
                            wche_pkg::K_TTICK: r_now <= r_now + 32'd1;
                            default: ;
                        endcase
                    end
                end
                S_HSCAN, S_ESCAN: begin
                    // Reads are issued one entry ahead of the compare.
                    r_pv <= r_issue;
                    if (r_issue) begin
                        r_npidx <= r_nptr;
                        if (nbr_last) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_nptr <= r_nptr + NIW'(1);
                        end
                    end
                    if (r_pv) begin
                        if (r_state == S_HSCAN) begin
                            if (r_nbr_vld[r_npidx]) begin
                                if (!r_hit && (r_q_naddr == r_src)) begin
                                    r_hit  <= 1'b1;
                                    r_slot <= r_npidx;
                                end
                            end else if (!r_free) begin
                                r_free  <= 1'b1;
                                r_fslot <= r_npidx;
                            end
                        end else if (e_cand && e_better) begin
                            r_found     <= 1'b1;
                            r_best_wt   <= r_q_nwt;
                            r_best_addr <= r_q_naddr;
                        end
                    end
                    if (!r_issue && !r_pv) begin
                        r_state <= (r_state == S_HSCAN) ? S_HFIN : S_ELEC;
                    end
                end
                S_HFIN: begin
                    if (!r_hit) begin
                        if (r_free) begin
                            r_nbr_vld[r_fslot] <= 1'b1;
                            r_nbr_cnt          <= r_nbr_cnt + NCW'(1);
                        end else begin
                            r_full <= 1'b1;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_MSCAN, S_DROP: begin
                    r_pv <= r_issue;
                    if (r_issue) begin
                        r_mpidx <= r_mptr;
                        if (mem_last) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_mptr <= r_mptr + MIW'(1);
                        end
                    end
                    if (r_pv) begin
                        if (r_state == S_MSCAN) begin
                            if (m_match) begin
                                r_mhit <= 1'b1;
                            end else if (!r_mem_vld[r_mpidx] && !r_mfree) begin
                                r_mfree  <= 1'b1;
                                r_mfslot <= r_mpidx;
                            end
                        end else if (m_match) begin
                            r_mem_vld[r_mpidx] <= 1'b0;
                            r_mem_cnt          <= r_mem_cnt - MCW'(1);
                        end
                    end
                    if (!r_issue && !r_pv) begin
                        r_state <= (r_state == S_MSCAN) ? S_MFIN : S_AGE_NXT;
                    end
                end
                S_MFIN: begin
                    // The reply goes out even when the member table is full.
                    if (!r_mhit) begin
                        if (r_mfree) begin
                            r_mem_vld[r_mfslot] <= 1'b1;
                            r_mem_cnt           <= r_mem_cnt + MCW'(1);
                        end else begin
                            r_full <= 1'b1;
                        end
                    end
                    r_act   <= wche_pkg::A_REPLY;
                    r_dest  <= r_src;
                    r_hout  <= r_my_addr;
                    r_state <= S_DONE;
                end
                S_ELEC: begin
                    if (!r_found && !r_head) begin
                        r_head     <= 1'b1;
                        r_cur_head <= r_my_addr;
                        r_act      <= wche_pkg::A_ANN;
                        r_dest     <= wche_pkg::BCAST;
                        r_hout     <= r_my_addr;
                    end else if (r_found && r_head) begin
                        // Giving up headship forgets every member.
                        r_head     <= 1'b0;
                        r_mem_vld  <= '0;
                        r_mem_cnt  <= '0;
                        r_cur_head <= r_best_addr;
                        r_act      <= wche_pkg::A_JOIN;
                        r_dest     <= r_best_addr;
                        r_hout     <= r_best_addr;
                    end
                    r_nptr  <= '0;
                    r_state <= S_AGE_RD;
                end
                S_AGE_RD: r_state <= S_AGE_CHK;
                S_AGE_CHK: begin
                    r_state <= S_AGE_NXT;
                    if (stale_c) begin
                        r_nbr_vld[r_nptr] <= 1'b0;
                        r_nbr_cnt         <= r_nbr_cnt - NCW'(1);
                        // A stale neighbor also leaves the member table.
                        if (r_mem_cnt != '0) begin
                            r_drop_addr <= r_q_naddr;
                            r_mptr      <= '0;
                            r_issue     <= 1'b1;
                            r_pv        <= 1'b0;
                            r_state     <= S_DROP;
                        end
                    end
                end
                S_AGE_NXT: begin
                    if (nbr_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_nptr  <= r_nptr + NIW'(1);
                        r_state <= S_AGE_RD;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_act  <= r_act;
            r_o_dest <= r_dest;
            r_o_hout <= r_hout;
            r_o_wt   <= r_mine;
            r_o_deg  <= 6'(r_nbr_cnt);
            r_o_head <= r_head;
            r_o_mcnt <= 6'(r_mem_cnt);
            r_o_full <= r_full;
        end
    end

    assign o_rsp.valid            = r_ov;
    assign o_rsp.action           = r_o_act;
    assign o_rsp.dest_address     = r_o_dest;
    assign o_rsp.head_address_out = r_o_hout;
    assign o_rsp.own_weight       = r_o_wt;
    assign o_rsp.degree           = r_o_deg;
    assign o_rsp.is_head          = r_o_head;
    assign o_rsp.member_count     = r_o_mcnt;
    assign o_rsp.table_full       = r_o_full;

    `WCHE_ASSERT_ALWAYS(a_nbr_cnt, i_clk, i_rst_n, r_nbr_cnt == NCW'($countones(r_nbr_vld)))
    `WCHE_ASSERT_ALWAYS(a_mem_cnt, i_clk, i_rst_n, r_mem_cnt == MCW'($countones(r_mem_vld)))
    `WCHE_ASSERT_ALWAYS(a_members_need_head, i_clk, i_rst_n, r_head || (r_mem_cnt == '0))
    `WCHE_ASSERT_IMPL(a_wgt_done_in_wgt, i_clk, i_rst_n, w_done, r_state == S_WGT)

endmodule

>>> tb/wche_checker.sv
`timescale 1ns / 1ps

// Watches the request and result channels, predicts each result and compares it.
module wche_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wche_in_if         req,
    wche_out_if        rsp,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int         o_errors,
    output int         o_pending
);

    typedef struct {
        logic [2:0]         action;
        logic [31:0]        dest;
        logic [31:0]        hout;
        logic signed [15:0] weight;
        logic [5:0]         degree;
        logic               is_head;
        logic [5:0]         members;
        logic               full;
    } t_result;

    t_result expected_q[$];

    logic [31:0] my_addr;
    logic [15:0] timeout;
    logic [11:0] dw, tw, mw, bw;
    logic [31:0] nb_addr [32];
    logic signed [15:0] nb_wt [32];
    logic [31:0] nb_seen [32];
    logic        nb_ok [32];
    logic [31:0] mb_addr [32];
    logic        mb_ok [32];
    logic        head;
    logic [31:0] cur_head;
    logic [31:0] ticks;

    function automatic int count_nb();
        int n = 0;
        for (int i = 0; i < 32; i++) n += nb_ok[i];
        return n;
    endfunction

    function automatic int count_mb();
        int n = 0;
        for (int i = 0; i < 32; i++) n += mb_ok[i];
        return n;
    endfunction

    // Fixed-point weight with round-half-up division by 1280 and saturation.
    function automatic logic signed [15:0] node_weight(int deg, int spd, int bat);
        longint s, t, q;
        s = longint'(dw) * (10 - deg) * 128 + longint'(tw) * 1280
          + longint'(mw) * (spd > 160 ? 160 : spd) * 8 + longint'(bw) * (256 - bat) * 5;
        t = s + 640;
        q = (t >= 0) ? t / 1280 : -((-t + 1279) / 1280);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    task automatic predict_request();
        t_result r;
        int slot, free_slot;
        logic found, known;
        logic signed [15:0] best_wt;
        logic [31:0] best_addr;
        r = '{default: 0};
        r.weight = node_weight(count_nb(), req.own_speed, req.own_battery);
        case (req.kind)
            wche_pkg::K_HELLO: begin
                if (req.src_address != my_addr) begin
                    slot = -1;
                    free_slot = -1;
                    for (int i = 0; i < 32; i++) begin
                        if (nb_ok[i]) begin
                            if (slot < 0 && nb_addr[i] == req.src_address) slot = i;
                        end else if (free_slot < 0) begin
                            free_slot = i;
                        end
                    end
                    if (slot < 0 && free_slot >= 0) begin
                        slot = free_slot;
                        nb_ok[slot] = 1;
                        nb_addr[slot] = req.src_address;
                    end
                    if (slot >= 0) begin
                        nb_wt[slot] = req.neighbor_weight;
                        nb_seen[slot] = ticks;
                    end else begin
                        r.full = 1;
                    end
                end
            end
            wche_pkg::K_ANN: begin
                if (!head && cur_head == 0) begin
                    cur_head = req.head_address;
                    r.action = wche_pkg::A_JOIN;
                    r.dest = req.head_address;
                    r.hout = req.head_address;
                end
            end
            wche_pkg::K_JREQ: begin
                if (head) begin
                    known = 0;
                    free_slot = -1;
                    for (int i = 0; i < 32; i++) begin
                        if (mb_ok[i]) begin
                            if (mb_addr[i] == req.src_address) known = 1;
                        end else if (free_slot < 0) begin
                            free_slot = i;
                        end
                    end
                    if (!known) begin
                        if (free_slot >= 0) begin
                            mb_ok[free_slot] = 1;
                            mb_addr[free_slot] = req.src_address;
                        end else begin
                            r.full = 1;
                        end
                    end
                    r.action = wche_pkg::A_REPLY;
                    r.dest = req.src_address;
                    r.hout = my_addr;
                end
            end
            wche_pkg::K_JREP: cur_head = req.head_address;
            wche_pkg::K_ELEC: begin
                found = 0;
                best_wt = 0;
                best_addr = 0;
                for (int i = 0; i < 32; i++) begin
                    if (nb_ok[i] && nb_wt[i] < r.weight) begin
                        if (!found || nb_wt[i] < best_wt
                                || (nb_wt[i] == best_wt && nb_addr[i] < best_addr)) begin
                            found = 1;
                            best_wt = nb_wt[i];
                            best_addr = nb_addr[i];
                        end
                    end
                end
                if (!found && !head) begin
                    head = 1;
                    cur_head = my_addr;
                    r.action = wche_pkg::A_ANN;
                    r.dest = wche_pkg::BCAST;
                    r.hout = my_addr;
                end else if (found && head) begin
                    head = 0;
                    for (int i = 0; i < 32; i++) mb_ok[i] = 0;
                    cur_head = best_addr;
                    r.action = wche_pkg::A_JOIN;
                    r.dest = best_addr;
                    r.hout = best_addr;
                end
                // Age out stale neighbors and any member with the same address.
                for (int i = 0; i < 32; i++) begin
                    if (nb_ok[i] && (ticks - nb_seen[i]) > {16'd0, timeout}) begin
                        for (int j = 0; j < 32; j++)
                            if (mb_ok[j] && mb_addr[j] == nb_addr[i]) mb_ok[j] = 0;
                        nb_ok[i] = 0;
                    end
                end
            end
            wche_pkg::K_HTICK: begin
                r.action = wche_pkg::A_HELLO;
                r.dest = wche_pkg::BCAST;
                r.hout = head ? my_addr : cur_head;
            end
            wche_pkg::K_TTICK: ticks = ticks + 1;
            default: ;
        endcase
        r.degree = 6'(count_nb());
        r.is_head = head;
        r.members = 6'(count_mb());
        expected_q = {expected_q, r};
    endtask

    task automatic compare_result();
        t_result e;
        if (expected_q.size() == 0) begin
            $error("result with no request outstanding");
            o_errors++;
            return;
        end
        e = expected_q.pop_front();
        if (rsp.action !== e.action) begin
            $error("action exp %0d got %0d", e.action, rsp.action); o_errors++;
        end
        if (rsp.dest_address !== e.dest) begin
            $error("dest_address exp %h got %h", e.dest, rsp.dest_address); o_errors++;
        end
        if (rsp.head_address_out !== e.hout) begin
            $error("head_address_out exp %h got %h", e.hout, rsp.head_address_out);
            o_errors++;
        end
        if (rsp.own_weight !== e.weight) begin
            $error("own_weight exp %0d got %0d", e.weight, rsp.own_weight); o_errors++;
        end
        if (rsp.degree !== e.degree) begin
            $error("degree exp %0d got %0d", e.degree, rsp.degree); o_errors++;
        end
        if (rsp.is_head !== e.is_head) begin
            $error("is_head exp %0d got %0d", e.is_head, rsp.is_head); o_errors++;
        end
        if (rsp.member_count !== e.members) begin
            $error("member_count exp %0d got %0d", e.members, rsp.member_count); o_errors++;
        end
        if (rsp.table_full !== e.full) begin
            $error("table_full exp %0d got %0d", e.full, rsp.table_full); o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            my_addr = 1;
            timeout = 50;
            dw = 179;
            tw = 26;
            mw = 26;
            bw = 26;
            for (int i = 0; i < 32; i++) begin
                nb_ok[i] = 0;
                mb_ok[i] = 0;
            end
            head = 0;
            cur_head = 0;
            ticks = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    wche_pkg::CFG_MY_ADDR: my_addr = i_cfg_data;
                    wche_pkg::CFG_TIMEOUT: timeout = i_cfg_data[15:0];
                    wche_pkg::CFG_DW:      dw = i_cfg_data[11:0];
                    wche_pkg::CFG_TW:      tw = i_cfg_data[11:0];
                    wche_pkg::CFG_MW:      mw = i_cfg_data[11:0];
                    wche_pkg::CFG_BW:      bw = i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready) compare_result();
            if (req.valid && req.ready) predict_request();
        end
        o_pending = expected_q.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

// Top of the cluster-head election bench. It builds stimulus and gives the verdict;
// the checker beside the block predicts and compares every result.
module tb_top;

    // The one request kind that the block leaves unused.
    localparam logic [2:0] K_SPARE = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    int          error_count;
    int          pending;

    wche_in_if  req_if ();
    wche_out_if rsp_if ();

    weighted_cluster_head_election dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_if.sink),
        .o_rsp     (rsp_if.source),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    wche_checker checker_inst (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_errors  (error_count),
        .o_pending (pending)
    );

    // A small pool of neighbor addresses keeps refreshes, joins and aging frequent.
    logic [31:0] addr_pool [48];
    logic [31:0] node_addr;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit: far beyond the slowest legal run, including stalls on both sides.
    initial begin
        #50ms;
        $display("tb_top: done, errors");
        $finish;
    end

    // Mostly short gaps, now and then a long one, sometimes none at all.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // The result side stalls on its own random pattern.
    initial begin
        rsp_if.ready <= 0;
        forever begin
            @(posedge i_clk);
            rsp_if.ready <= ($urandom_range(0, 99) < 70);
            if ($urandom_range(0, 99) < 3) begin
                repeat ($urandom_range(10, 80)) @(posedge i_clk);
            end
        end
    end

    // Presents one request and holds it until the block takes it. With no gap the
    // valid line stays high and the next request follows directly.
    task automatic send_request(logic [2:0] kind, logic [31:0] src, logic [31:0] hd,
                                logic [15:0] nw, logic [9:0] spd, logic [8:0] bat);
        int gap;
        req_if.valid <= 1;
        req_if.kind <= kind;
        req_if.src_address <= src;
        req_if.head_address <= hd;
        req_if.neighbor_weight <= nw;
        req_if.own_speed <= spd;
        req_if.own_battery <= bat;
        do @(posedge i_clk); while (!req_if.ready);
        gap = gap_length();
        if (gap > 0) begin
            req_if.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Random request weighted toward hellos from the pool and time ticks.
    task automatic random_request();
        int r;
        logic [2:0] kind;
        logic [31:0] src, hd;
        r = $urandom_range(0, 99);
        if (r < 35) kind = wche_pkg::K_HELLO;
        else if (r < 42) kind = wche_pkg::K_ANN;
        else if (r < 55) kind = wche_pkg::K_JREQ;
        else if (r < 60) kind = wche_pkg::K_JREP;
        else if (r < 72) kind = wche_pkg::K_ELEC;
        else if (r < 78) kind = wche_pkg::K_HTICK;
        else if (r < 97) kind = wche_pkg::K_TTICK;
        else kind = K_SPARE;
        src = ($urandom_range(0, 9) == 0) ? $urandom() : addr_pool[$urandom_range(0, 47)];
        if ($urandom_range(0, 30) == 0) src = node_addr;
        hd = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom();
        send_request(kind, src, hd, 16'($urandom()), 10'($urandom_range(0, 1023)),
                     9'(($urandom_range(0, 9) == 0) ? $urandom_range(257, 511)
                                                    : $urandom_range(0, 256)));
    endtask

    // Stops sending, waits for every result, then lets any internal work settle.
    task automatic wait_idle();
        req_if.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2500) @(posedge i_clk);
    endtask

    // Drives one register write with the write enable set; the caller drops it after the last write.
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n <= 0;
        i_cfg_we <= 0;
        i_cfg_idx <= wche_pkg::CFG_MY_ADDR;
        i_cfg_data <= 0;
        req_if.valid <= 0;
        req_if.kind <= wche_pkg::K_HELLO;
        req_if.src_address <= 0;
        req_if.head_address <= 0;
        req_if.neighbor_weight <= 0;
        req_if.own_speed <= 0;
        req_if.own_battery <= 0;
        for (int i = 0; i < 48; i++) addr_pool[i] = $urandom() | 32'h100;
        node_addr = 1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part at reset settings: an empty election, extremes of the fields,
        // every kind, the ignored own hello and the unused kind.
        send_request(wche_pkg::K_HTICK, 0, 0, 0, 0, 0);
        send_request(wche_pkg::K_ELEC, 0, 0, 0, 1023, 511);
        send_request(wche_pkg::K_JREQ, 32'hFFFF_FFFF, 0, 0, 160, 256);
        send_request(wche_pkg::K_JREQ, 32'hFFFF_FFFF, 0, 0, 161, 0);
        send_request(wche_pkg::K_HELLO, 1, 0, 16'h8000, 0, 0);
        send_request(wche_pkg::K_HELLO, 32'hFFFF_FFFF, 0, 16'h8000, 0, 0);
        send_request(wche_pkg::K_HELLO, 32'h0000_0000, 0, 16'h8000, 0, 0);
        send_request(wche_pkg::K_HELLO, 32'h0000_0000, 0, 16'h7FFF, 0, 0);
        send_request(wche_pkg::K_ELEC, 0, 0, 0, 0, 0);
        send_request(wche_pkg::K_HTICK, 0, 0, 0, 0, 0);
        send_request(wche_pkg::K_ANN, 5, 32'hFFFF_FFFF, 0, 0, 0);
        send_request(wche_pkg::K_JREP, 0, 0, 0, 0, 0);
        send_request(wche_pkg::K_ANN, 5, 32'hAAAA_5555, 0, 0, 0);
        send_request(wche_pkg::K_ANN, 5, 32'h5555_AAAA, 0, 0, 0);
        send_request(K_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1023, 511);
        send_request(wche_pkg::K_TTICK, 0, 0, 0, 0, 0);
        // Fill the neighbor table past its depth so four hellos are dropped.
        for (int i = 0; i < 34; i++) begin
            send_request(wche_pkg::K_HELLO, 32'h200 + i, 0, 16'h7000, 5, 100);
        end
        wait_idle();

        // Extreme settings: short timeout, weights at both ends, a maximal address.
        write_reg(wche_pkg::CFG_MY_ADDR, 32'hFFFF_FFFF);
        write_reg(wche_pkg::CFG_TIMEOUT, 1);
        write_reg(wche_pkg::CFG_DW, 12'hFFF);
        write_reg(wche_pkg::CFG_TW, 0);
        write_reg(wche_pkg::CFG_MW, 12'hFFF);
        write_reg(wche_pkg::CFG_BW, 12'hFFF);
        i_cfg_we <= 0;
        node_addr = 32'hFFFF_FFFF;

        for (int n = 0; n < 650; n++) begin
            if (n == 160) begin
                wait_idle();
                write_reg(wche_pkg::CFG_MY_ADDR, 32'h0000_0001);
                write_reg(wche_pkg::CFG_TIMEOUT, 16'hFFFF);
                write_reg(wche_pkg::CFG_DW, 0);
                write_reg(wche_pkg::CFG_TW, 12'hFFF);
                write_reg(wche_pkg::CFG_MW, 0);
                write_reg(wche_pkg::CFG_BW, 0);
                i_cfg_we <= 0;
                node_addr = 1;
            end else if (n == 330 || n == 490) begin
                wait_idle();
                node_addr = $urandom() | 1;
                write_reg(wche_pkg::CFG_MY_ADDR, node_addr);
                write_reg(wche_pkg::CFG_TIMEOUT, $urandom_range(3, 40));
                write_reg(wche_pkg::CFG_DW, $urandom_range(0, 4095));
                write_reg(wche_pkg::CFG_TW, $urandom_range(0, 4095));
                write_reg(wche_pkg::CFG_MW, $urandom_range(0, 4095));
                write_reg(wche_pkg::CFG_BW, $urandom_range(0, 4095));
                i_cfg_we <= 0;
            end
            random_request();
        end

        wait_idle();
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
